### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the keyframe interpolator.
// Included by the top level; the macros compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define KVI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define KVI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KVI_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define KVI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/kvi_pkg.sv
// Types, codes and helpers of the keyframe vector interpolator.
// No dependencies; used by the divider, the lerp unit, the top level and the testbench.
package kvi_pkg;

  localparam int FACTOR_W = 16;
  localparam int CNT_W    = $clog2(FACTOR_W);

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] ST_INTERP = 2'd0;
  localparam logic [1:0] ST_SINGLE = 2'd1;
  localparam logic [1:0] ST_BEYOND = 2'd2;

  localparam logic [1:0] COMP_X    = 2'd0;
  localparam logic [1:0] COMP_Y    = 2'd1;
  localparam logic [1:0] COMP_Z    = 2'd2;
  localparam logic [1:0] COMP_LAST = COMP_Z;

  typedef struct packed {
    logic               action;
    logic [5:0]         key_index;
    logic [31:0]        key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [31:0]        query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [6:0] keys_in_use;
  } cfg_item_t;

  typedef struct packed {
    logic [31:0] key_time;
    logic [31:0] key_x;
    logic [31:0] key_y;
    logic [31:0] key_z;
  } key_entry_t;

  typedef struct packed {
    logic                done;
    logic [FACTOR_W-1:0] quot;
  } div_stat_t;

  typedef struct packed {
    logic                load;
    logic [31:0]         a;
    logic [31:0]         b;
    logic [FACTOR_W-1:0] f;
  } lerp_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HOLD0,
    S_SCAN,
    S_FETCH_A,
    S_FETCH_B,
    S_FETCH_C,
    S_DIV,
    S_LMUL,
    S_LACC,
    S_EMIT
  } state_t;

  function automatic logic [31:0] comp_sel(key_entry_t e, logic [1:0] c);
    logic [31:0] v;
    case (c)
      COMP_X:  v = e.key_x;
      COMP_Y:  v = e.key_y;
      COMP_Z:  v = e.key_z;
      default: v = e.key_x;
    endcase
    return v;
  endfunction

endpackage

### rtl/kvi_stream_if.sv
// Valid/ready channel carrying one payload struct per transaction.
// Payload type comes from kvi_pkg at the point of instantiation.
interface kvi_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/kvi_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kvi_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/kvi_divider.sv
// Restoring divider, one quotient bit per cycle: floor((num << 16) / den), num < den.
// Depends on kvi_pkg.
module kvi_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         num,
  input  logic [31:0]         den,
  output kvi_pkg::div_stat_t  stat
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [kvi_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [31:0]                   rem_r, rem_nxt;
  logic [31:0]                   den_r, den_nxt;
  logic [kvi_pkg::FACTOR_W-1:0]  q_r, q_nxt;
  logic [32:0]                   rem2;
  logic [33:0]                   diff;
  logic                          ge;

  assign rem2 = {rem_r, 1'b0};
  assign diff = {1'b0, rem2} - {2'b00, den_r};
  assign ge   = ~diff[33];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = num;
      den_nxt  = den;
      q_nxt    = '0;
    end else if (busy_r) begin
      // remainder stays below den, so it fits 32 bits after the subtract
      rem_nxt = ge ? diff[31:0] : rem2[31:0];
      q_nxt   = {q_r[kvi_pkg::FACTOR_W-2:0], ge};
      cnt_nxt = cnt_r + kvi_pkg::CNT_W'(1);
      if (cnt_r == kvi_pkg::CNT_W'(kvi_pkg::FACTOR_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign stat.done = done_r;
  assign stat.quot = q_r;

endmodule

### rtl/kvi_lerp_unit.sv
// Shared lerp datapath: registered f*(b-a), then a + floor(prod/65536), saturated.
// Depends on kvi_pkg.
module kvi_lerp_unit (
  input  logic               clk,
  input  kvi_pkg::lerp_req_t req,
  output logic [31:0]        res
);

  logic signed [32:0] d;
  logic signed [49:0] prod_nxt;
  logic signed [49:0] prod_r;
  logic signed [31:0] a_r;
  logic signed [33:0] frac;
  logic signed [34:0] sum;

  assign d        = $signed({req.b[31], req.b}) - $signed({req.a[31], req.a});
  assign prod_nxt = $signed({1'b0, req.f}) * d;

  always_ff @(posedge clk) begin
    if (req.load) begin
      prod_r <= prod_nxt;
      a_r    <= $signed(req.a);
    end
  end

  // arithmetic shift gives rounding toward minus infinity
  assign frac = prod_r[49:16];
  assign sum  = $signed({{3{a_r[31]}}, a_r}) + $signed({frac[33], frac});

  always_comb begin
    if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111) begin
      res = sum[31:0];
    end else if (sum[34]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
  end

endmodule

### rtl/keyframe_vector_interpolator_unit.sv
// Keyframe vector interpolator: keyframe table in RAM plus a sequenced lerp datapath.
// Depends on kvi_pkg, kvi_stream_if, kvi_ram, kvi_divider, kvi_lerp_unit, assert_macros.svh.
//
// Usage:
//  - cfg_ch (kvi_pkg::cfg_item_t): sets keys_in_use; always ready. Write only while idle.
//  - in_ch (kvi_pkg::in_item_t): action ACT_WRITE stores a keyframe at key_index
//    (slots at or past MAX_KEYS are dropped) and produces no result; ACT_QUERY
//    interpolates at query_time and produces one out_ch transaction.
//  - out_ch (kvi_pkg::out_item_t): x/y/z in signed Q16.16 and a status code.
// Sequencing:
//  - A keyframe write is stored from S_IDLE; in_ch is ready again the next cycle.
//  - A query with zero or one key goes through S_HOLD0 to S_EMIT and the output register.
//  - Otherwise: accept, S_SCAN over one segment end after another (key 1 up to the
//    last used key, through the single RAM read port), S_FETCH_A/B/C, S_DIV when the
//    serial divider runs (one quotient bit per cycle), S_LMUL and S_LACC on the shared
//    multiplier for each of the three components (multiply then add/saturate), then S_EMIT.
//  - in_ch.ready is low while a query is in flight.
// Reset clears the sequencer, keys_in_use and the output valid; the table is not
// cleared. If out_ch stalls, the block still takes writes and starts the next
// query, which waits in its emit step until the output register frees up.
module keyframe_vector_interpolator_unit #(
  parameter int MAX_KEYS = 64
) (
  input logic          clk,
  input logic          rst_n,
  kvi_stream_if.sink   cfg_ch,
  kvi_stream_if.sink   in_ch,
  kvi_stream_if.source out_ch
);

`include "assert_macros.svh"

  localparam int AW = $clog2(MAX_KEYS);
  localparam int NW = $clog2(MAX_KEYS + 1);
  localparam int EW = $bits(kvi_pkg::key_entry_t);

  // sequencer state
  kvi_pkg::state_t             state_r, state_nxt;
  logic [6:0]                  keys_r, keys_nxt;
  logic [31:0]                 t_r, t_nxt;
  logic [AW-1:0]               last_r, last_nxt;
  logic [AW-1:0]               chk_r, chk_nxt;
  logic [AW-1:0]               seg_r, seg_nxt;
  logic                        found_r, found_nxt;
  kvi_pkg::key_entry_t         start_r, start_nxt;
  kvi_pkg::key_entry_t         end_r, end_nxt;
  logic [kvi_pkg::FACTOR_W-1:0] f_r, f_nxt;
  logic [1:0]                  comp_r, comp_nxt;
  logic [31:0]                 res_r [3];
  logic [31:0]                 res_nxt [3];
  logic [1:0]                  status_r, status_nxt;
  logic                        out_valid_r, out_valid_nxt;
  kvi_pkg::out_item_t          out_pl_r, out_pl_nxt;

  // table RAM
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  kvi_pkg::key_entry_t         ram_wdata;
  logic [EW-1:0]               ram_rdata;
  kvi_pkg::key_entry_t         rd_entry;

  // shared units
  logic                        div_start;
  logic [31:0]                 div_num, div_den;
  kvi_pkg::div_stat_t          div_stat;
  kvi_pkg::lerp_req_t          lerp_req;
  logic [31:0]                 lerp_res;

  logic [NW-1:0]               n_used;

  // assertion terms
  logic                        query_acc;
  logic                        emit_wait;

  kvi_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_KEYS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_entry = kvi_pkg::key_entry_t'(ram_rdata);

  kvi_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat)
  );

  kvi_lerp_unit u_lerp (
    .clk (clk),
    .req (lerp_req),
    .res (lerp_res)
  );

  // divider operands are valid in S_FETCH_C: start_r is t0, read data is t1
  assign div_num = t_r - start_r.key_time;
  assign div_den = rd_entry.key_time - start_r.key_time;

  // key count clipped to table depth
  always_comb begin
    if (int'(keys_r) > MAX_KEYS) begin
      n_used = NW'(MAX_KEYS);
    end else begin
      n_used = NW'(keys_r);
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == kvi_pkg::S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_pl_r;

  always_comb begin
    state_nxt     = state_r;
    keys_nxt      = keys_r;
    t_nxt         = t_r;
    last_nxt      = last_r;
    chk_nxt       = chk_r;
    seg_nxt       = seg_r;
    found_nxt     = found_r;
    start_nxt     = start_r;
    end_nxt       = end_r;
    f_nxt         = f_r;
    comp_nxt      = comp_r;
    res_nxt       = res_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_pl_nxt    = out_pl_r;

    ram_we          = 1'b0;
    ram_waddr       = AW'(in_ch.payload.key_index);
    ram_wdata.key_time = in_ch.payload.key_time;
    ram_wdata.key_x    = in_ch.payload.key_x;
    ram_wdata.key_y    = in_ch.payload.key_y;
    ram_wdata.key_z    = in_ch.payload.key_z;
    ram_re          = 1'b0;
    ram_raddr       = '0;
    div_start       = 1'b0;
    lerp_req.load   = 1'b0;
    lerp_req.a      = kvi_pkg::comp_sel(start_r, comp_r);
    lerp_req.b      = kvi_pkg::comp_sel(end_r, comp_r);
    lerp_req.f      = f_r;

    if (cfg_ch.valid) begin
      keys_nxt = cfg_ch.payload.keys_in_use;
    end

    case (state_r)
      kvi_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.payload.action == kvi_pkg::ACT_WRITE) begin
            ram_we = (int'(in_ch.payload.key_index) < MAX_KEYS);
          end else begin
            t_nxt  = in_ch.payload.query_time;
            ram_re = 1'b1;
            if (n_used <= NW'(1)) begin
              ram_raddr = '0;
              state_nxt = kvi_pkg::S_HOLD0;
            end else begin
              // scan starts at key 1: first segment whose end time exceeds t
              last_nxt  = AW'(n_used - NW'(1));
              chk_nxt   = AW'(1);
              ram_raddr = AW'(1);
              state_nxt = kvi_pkg::S_SCAN;
            end
          end
        end
      end
      kvi_pkg::S_HOLD0: begin
        res_nxt[kvi_pkg::COMP_X] = rd_entry.key_x;
        res_nxt[kvi_pkg::COMP_Y] = rd_entry.key_y;
        res_nxt[kvi_pkg::COMP_Z] = rd_entry.key_z;
        status_nxt = kvi_pkg::ST_SINGLE;
        state_nxt  = kvi_pkg::S_EMIT;
      end
      kvi_pkg::S_SCAN: begin
        // read data is key chk_r; prefetch the next one
        ram_re    = 1'b1;
        ram_raddr = chk_r + AW'(1);
        if (t_r < rd_entry.key_time) begin
          found_nxt = 1'b1;
          seg_nxt   = chk_r - AW'(1);
          state_nxt = kvi_pkg::S_FETCH_A;
        end else if (chk_r == last_r) begin
          // at or past the last key: fall back to segment 0
          found_nxt = 1'b0;
          seg_nxt   = '0;
          state_nxt = kvi_pkg::S_FETCH_A;
        end else begin
          chk_nxt = chk_r + AW'(1);
        end
      end
      kvi_pkg::S_FETCH_A: begin
        ram_re    = 1'b1;
        ram_raddr = seg_r;
        state_nxt = kvi_pkg::S_FETCH_B;
      end
      kvi_pkg::S_FETCH_B: begin
        start_nxt = rd_entry;
        ram_re    = 1'b1;
        ram_raddr = seg_r + AW'(1);
        state_nxt = kvi_pkg::S_FETCH_C;
      end
      kvi_pkg::S_FETCH_C: begin
        end_nxt  = rd_entry;
        comp_nxt = kvi_pkg::COMP_X;
        if (t_r <= start_r.key_time) begin
          f_nxt     = '0;
          state_nxt = kvi_pkg::S_LMUL;
        end else if (t_r >= rd_entry.key_time) begin
          f_nxt     = '1;
          state_nxt = kvi_pkg::S_LMUL;
        end else begin
          div_start = 1'b1;
          state_nxt = kvi_pkg::S_DIV;
        end
      end
      kvi_pkg::S_DIV: begin
        if (div_stat.done) begin
          f_nxt     = div_stat.quot;
          state_nxt = kvi_pkg::S_LMUL;
        end
      end
      kvi_pkg::S_LMUL: begin
        lerp_req.load = 1'b1;
        state_nxt     = kvi_pkg::S_LACC;
      end
      kvi_pkg::S_LACC: begin
        res_nxt[comp_r] = lerp_res;
        if (comp_r == kvi_pkg::COMP_LAST) begin
          status_nxt = found_r ? kvi_pkg::ST_INTERP : kvi_pkg::ST_BEYOND;
          state_nxt  = kvi_pkg::S_EMIT;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = kvi_pkg::S_LMUL;
        end
      end
      kvi_pkg::S_EMIT: begin
        // wait for the output register to drain
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt    = 1'b1;
          out_pl_nxt.out_x = res_r[kvi_pkg::COMP_X];
          out_pl_nxt.out_y = res_r[kvi_pkg::COMP_Y];
          out_pl_nxt.out_z = res_r[kvi_pkg::COMP_Z];
          out_pl_nxt.status = status_r;
          state_nxt        = kvi_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = kvi_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kvi_pkg::S_IDLE;
      keys_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      keys_r      <= keys_nxt;
      out_valid_r <= out_valid_nxt;
    end
    t_r      <= t_nxt;
    last_r   <= last_nxt;
    chk_r    <= chk_nxt;
    seg_r    <= seg_nxt;
    found_r  <= found_nxt;
    start_r  <= start_nxt;
    end_r    <= end_nxt;
    f_r      <= f_nxt;
    comp_r   <= comp_nxt;
    res_r    <= res_nxt;
    status_r <= status_nxt;
    out_pl_r <= out_pl_nxt;
  end

  assign query_acc = in_ch.valid && in_ch.ready &&
                     (in_ch.payload.action == kvi_pkg::ACT_QUERY);
  assign emit_wait = (state_r == kvi_pkg::S_EMIT) && out_valid_r && !out_ch.ready;

  // scan never runs past the last valid key
  `KVI_ASSERT_NOW(a_scan_bound, clk, rst_n, state_r == kvi_pkg::S_SCAN, chk_r <= last_r)
  // divider finishes only while the sequencer waits on it
  `KVI_ASSERT_NOW(a_div_done, clk, rst_n, div_stat.done, state_r == kvi_pkg::S_DIV)
  // an accepted query keeps the block busy
  `KVI_ASSERT_NEXT(a_query_busy, clk, rst_n, query_acc, state_r != kvi_pkg::S_IDLE)
  // a finished result does not overwrite one still waiting
  `KVI_ASSERT_NEXT(a_emit_hold, clk, rst_n, emit_wait, state_r == kvi_pkg::S_EMIT)

endmodule

### tb/kvi_checker.sv
// Scoreboard for keyframe_vector_interpolator_unit: mirrors the key table and count.
// It predicts each query result and compares it with the out channel.
// Depends on kvi_pkg; instantiated beside the block by tb_top.
module kvi_checker
  import kvi_pkg::*;
#(
  parameter int MAX_KEYS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  cfg_item_t cfg_data,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        failures,
  output int        pending,
  output int        checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] time_tab [MAX_KEYS];
  logic [31:0] x_tab [MAX_KEYS];
  logic [31:0] y_tab [MAX_KEYS];
  logic [31:0] z_tab [MAX_KEYS];
  logic [6:0]  key_count;
  out_item_t   awaited_q [$];
  int          fail_cnt = 0;
  int          check_cnt = 0;

  // start + f * (end - start) in Q16.16, floored, saturated to 32 bits
  function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                        input logic [15:0] f);
    longint sa, sd, acc, q;
    sa  = longint'(signed'(a));
    sd  = longint'(signed'(b)) - sa;
    acc = sa * 65536 + longint'(f) * sd;
    q   = acc >>> 16;
    if (q > longint'(32'sh7FFF_FFFF)) q = longint'(32'sh7FFF_FFFF);
    else if (q < longint'(32'sh8000_0000)) q = longint'(32'sh8000_0000);
    return q[31:0];
  endfunction

  function automatic out_item_t interpolate(input logic [31:0] qt);
    out_item_t   res;
    int          n, seg;
    bit          found;
    logic [31:0] t0, t1;
    logic [15:0] f;
    n = (key_count > MAX_KEYS) ? MAX_KEYS : int'(key_count);
    if (n <= 1) begin
      res.out_x  = x_tab[0];
      res.out_y  = y_tab[0];
      res.out_z  = z_tab[0];
      res.status = ST_SINGLE;
      return res;
    end
    seg   = 0;
    found = 1'b0;
    for (int i = 0; i + 1 < n; i++) begin
      if (!found && qt < time_tab[i+1]) begin
        seg   = i;
        found = 1'b1;
      end
    end
    // at or past the last key the block falls back to segment 0
    t0 = time_tab[seg];
    t1 = time_tab[seg+1];
    if (qt <= t0) f = '0;
    else if (qt >= t1) f = 16'hFFFF;
    else f = 16'((64'(qt - t0) << 16) / 64'(t1 - t0));
    res.out_x  = blend(x_tab[seg], x_tab[seg+1], f);
    res.out_y  = blend(y_tab[seg], y_tab[seg+1], f);
    res.out_z  = blend(z_tab[seg], z_tab[seg+1], f);
    res.status = found ? ST_INTERP : ST_BEYOND;
    return res;
  endfunction

  function automatic void compare(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      fail_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      key_count = '0;
      awaited_q.delete();
    end else begin
      // results first: a result never belongs to a query taken at the same edge
      if (out_valid && out_ready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h %h %h status %0d",
                   $time, out_data.out_x, out_data.out_y, out_data.out_z, out_data.status);
          fail_cnt++;
        end else begin
          want = awaited_q.pop_front();
          check_cnt++;
          compare("out_x", want.out_x, out_data.out_x);
          compare("out_y", want.out_y, out_data.out_y);
          compare("out_z", want.out_z, out_data.out_z);
          compare("status", 32'(want.status), 32'(out_data.status));
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.action == ACT_QUERY) begin
          awaited_q.push_back(interpolate(in_data.query_time));
        end else if (int'(in_data.key_index) < MAX_KEYS) begin
          time_tab[in_data.key_index] = in_data.key_time;
          x_tab[in_data.key_index]    = in_data.key_x;
          y_tab[in_data.key_index]    = in_data.key_y;
          z_tab[in_data.key_index]    = in_data.key_z;
        end
      end
      if (cfg_valid && cfg_ready) key_count = cfg_data.keys_in_use;
    end
    failures <= fail_cnt;
    pending  <= awaited_q.size();
    checked  <= check_cnt;
  end

endmodule

### tb/tb_top.sv
// Top of the keyframe interpolator testbench: clock, reset, stimulus and verdict.
// Depends on kvi_pkg, kvi_stream_if, keyframe_vector_interpolator_unit and kvi_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kvi_pkg::*;

  localparam int MAX_KEYS    = 64;
  localparam int ITEM_TARGET = 1700;
  // the slowest query is one at 64 keys; give it time to finish with some margin
  localparam int SETTLE_CYCLES = 120;
  // longest legal gap without any transaction is a settle pause or one slow query
  localparam int STALL_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   quiet = 1'b0;   // no idling on either side while set
  int   failures, pending, checked;
  int   items_sent = 0;
  int   writes_sent = 0;
  int   queries_sent = 0;
  int   settings = 0;
  int   idle_cycles = 0;

  kvi_stream_if #(.payload_t(cfg_item_t)) cfg_if ();
  kvi_stream_if #(.payload_t(in_item_t))  in_if ();
  kvi_stream_if #(.payload_t(out_item_t)) out_if ();

  keyframe_vector_interpolator_unit #(.MAX_KEYS(MAX_KEYS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_if),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  kvi_checker #(.MAX_KEYS(MAX_KEYS)) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_if.valid),
    .cfg_ready (cfg_if.ready),
    .cfg_data  (cfg_if.payload),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .in_data   (in_if.payload),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.payload),
    .failures  (failures),
    .pending   (pending),
    .checked   (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: drops ready at random with probability 11/100, never while quiet.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_if.ready <= quiet || ($urandom_range(0, 99) >= 11);
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input transaction. Valid is left high on return so that a following
  // call in the same step keeps it up; anything that lets time pass lowers it.
  task automatic send_item(input in_item_t it);
    if (!quiet && $urandom_range(0, 99) < 11) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= it;
    do @(posedge clk); while (!in_if.ready);
    items_sent++;
  endtask

  task automatic write_key(input logic [5:0] slot, input logic [31:0] t,
                           input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    in_item_t it;
    it.action     = ACT_WRITE;
    it.key_index  = slot;
    it.key_time   = t;
    it.key_x      = x;
    it.key_y      = y;
    it.key_z      = z;
    it.query_time = $urandom();   // don't-care on a write
    send_item(it);
    writes_sent++;
  endtask

  task automatic ask(input logic [31:0] t);
    in_item_t it;
    it.action     = ACT_QUERY;
    it.key_index  = 6'($urandom());   // key fields are don't-care on a query
    it.key_time   = $urandom();
    it.key_x      = $urandom();
    it.key_y      = $urandom();
    it.key_z      = $urandom();
    it.query_time = t;
    send_item(it);
    queries_sent++;
  endtask

  // Sender holds off until every result is back, then lets a write or a
  // query with no result still in the pipe finish.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_key_count(input logic [6:0] n);
    wait_idle();
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= '{keys_in_use: n};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    settings++;
  endtask

  // Mostly full-range values, with rails and small magnitudes mixed in.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int unsigned times_q [$];
    logic [6:0]  n;
    logic [31:0] qt, t;
    int          cnt, nq, j, mode, phase, r, slot;
    bit          broken;

    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // Count is 0 after reset: key 0 must come back untouched, status single.
    write_key(6'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    // top slot, all index bits set; not read until a full table overwrites it
    write_key(6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    ask(32'h0000_0000);
    ask(32'hFFFF_FFFF);
    set_key_count(7'd1);
    ask(32'h0001_0000);
    // Keys 1 and 2 share a time (zero-length segment), key 3 sits at the top.
    write_key(6'd1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_8000);
    write_key(6'd2, 32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000);
    write_key(6'd3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
    set_key_count(7'd4);
    ask(32'h0000_0000);    // before the first key: factor 0
    ask(32'h0001_0000);    // exactly on key 0
    ask(32'h0001_8000);    // half way across a full-scale swing
    ask(32'h0002_0000);    // lands on the duplicated time
    ask(32'h8000_0000);
    ask(32'hFFFF_FFFE);    // factor just under one
    ask(32'hFFFF_FFFF);    // at the last key: segment 0, beyond flag
    set_key_count(7'd2);
    ask(32'h0001_FFFF);
    ask(32'h0002_0000);    // at the last of two keys: segment 0, beyond flag

    // ---- random part ----
    // Each phase sets a key count, writes a table (mostly ascending times),
    // then queries around and between the keys with the odd rewrite mixed in.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      case (phase)
        0: n = 7'd64;
        1: n = 7'd127;
        2: n = 7'd0;
        3: n = 7'd1;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 5) n = 7'd0;
          else if (r < 10) n = 7'd1;
          else if (r < 50) n = 7'($urandom_range(2, 6));
          else if (r < 80) n = 7'($urandom_range(7, 20));
          else if (r < 88) n = 7'($urandom_range(21, 63));
          else if (r < 96) n = 7'd64;
          else n = 7'($urandom_range(65, 127));
        end
      endcase
      // a long stretch without idling on either side
      quiet = (phase >= 8 && phase < 12);
      set_key_count(n);

      // with zero keys the block still reads key 0, so always write it
      cnt = (n > MAX_KEYS) ? MAX_KEYS : ((n == 0) ? 1 : int'(n));
      mode   = $urandom_range(0, 3);
      broken = ($urandom_range(0, 9) == 0);
      times_q.delete();
      for (int i = 0; i < cnt; i++) begin
        case (mode)
          0:       times_q.push_back($urandom());
          1:       times_q.push_back($urandom_range(0, 4 * cnt));   // dense, duplicates
          default: times_q.push_back($urandom_range(0, 32'h00FF_FFFF));
        endcase
      end
      if (!broken) times_q.sort();
      for (int i = 0; i < cnt; i++)
        write_key(6'(i), times_q[i], pick_coord(), pick_coord(), pick_coord());

      nq = $urandom_range(15, 45);
      for (int k = 0; k < nq; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          // rewrite between queries; may well break the time order
          slot = $urandom_range(0, MAX_KEYS - 1);
          t = (cnt > 1) ? times_q[$urandom_range(0, cnt - 1)] + $urandom_range(0, 3)
                        : $urandom();
          write_key(6'(slot), t, pick_coord(), pick_coord(), pick_coord());
          if (slot < cnt) times_q[slot] = t;
        end else begin
          j = $urandom_range(0, cnt - 1);
          case ($urandom_range(0, 7))
            0: qt = times_q[j];
            1: qt = times_q[j] - 1;
            2: qt = times_q[j] + 1;
            3, 4: begin
              if (j + 1 < cnt && times_q[j] <= times_q[j+1])
                qt = $urandom_range(times_q[j], times_q[j+1]);
              else
                qt = $urandom();
            end
            5: qt = $urandom_range(0, 1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: qt = $urandom();
          endcase
          ask(qt);
        end
      end
      phase++;
    end

    quiet = 1'b0;
    wait_idle();
    $display("Run covered %0d keyframe writes and %0d queries over %0d key-count settings,",
             writes_sent, queries_sent, settings);
    $display("from empty to above the table size; %0d results compared.", checked);
    if (failures == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/kvi_pkg.sv
rtl/kvi_stream_if.sv
rtl/kvi_ram.sv
rtl/kvi_divider.sv
rtl/kvi_lerp_unit.sv
rtl/keyframe_vector_interpolator_unit.sv
tb/kvi_checker.sv
tb/tb_top.sv
